[sv/chm_pkg.sv]
`default_nettype none
package chm_pkg;
	localparam int BUCKETS = 64;
	localparam int POOL_ENTRIES = 256;
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int LW = $clog2(POOL_ENTRIES + 1);
	localparam int EW = 32 + 32 + LW;

	typedef enum logic {
		REQ_STORE  = 1'b0,
		REQ_LOOKUP = 1'b1
	} req_type_t;

	typedef struct packed {
		logic        req_type;
		logic [31:0] key;
		logic [31:0] store_value;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [31:0] read_value;
		logic        full_res;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_CHECK,
		ST_LINK,
		ST_OUT
	} state_t;

	function automatic logic [BW-1:0] bucket_of(input logic [31:0] k);
		logic [31:0] mag;
		mag = k[31] ? (32'd0 - k) : k;
		return BW'(mag % BUCKETS);
	endfunction
endpackage
`default_nettype wire

[sv/chm_if.sv]
`default_nettype none
interface chm_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [31:0] key;
	logic [31:0] store_value;
	modport source(output valid, req_type, key, store_value, input ready);
	modport sink(input valid, req_type, key, store_value, output ready);
endinterface

interface chm_rsp_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] read_value;
	logic        full_res;
	modport source(output valid, found, read_value, full_res, input ready);
	modport sink(input valid, found, read_value, full_res, output ready);
endinterface
`default_nettype wire

[sv/chm_ram.sv]
`default_nettype none
module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[sv/chained_hash_map.sv]
// chained_hash_map: integer-keyed map with separate chaining.
// Channels: req (req_type, key, store_value) and rsp (found, read_value,
// full_res), valid/ready each; one response per request, in order.
// Bucket = |key| mod BUCKETS. Chain heads live in a BUCKETS-deep RAM with
// one valid flop per bucket; entries (key, value, link) in a second RAM of
// POOL_ENTRIES words. Both RAMs have a registered read.
// After a request transaction the head RAM output is used in ST_HEAD, then
// each chain entry visited is compared in an ST_CHECK state, while the read
// of the next entry overlaps the compare. Appending a new key behind an
// existing entry passes through ST_LINK to patch that entry's link before
// ST_OUT presents the response.
// Only one request is in flight: req.ready is high only while idle, and a
// stalled receiver holds rsp steady and keeps req.ready low.
// Reset clears the head valid flops and the pool count; entries are only
// read after they were written, so neither RAM needs clearing.
`default_nettype none
module chained_hash_map (
	input wire logic clk,
	input wire logic arst_n,
	chm_req_if.sink   req,
	chm_rsp_if.source rsp
);
	import chm_pkg::*;

	state_t             state_q, state_d;
	req_t               r_q;
	logic [BW-1:0]      b_q;
	logic [LW-1:0]      cur_q, last_q, used_q, steps_q;
	logic [63:0]        lsave_q;
	logic [BUCKETS-1:0] hv_q;
	rsp_t               o_q;
	logic               we, hwe, hit, miss, step, stop, add, walking;
	logic [PW-1:0]      waddr, raddr;
	logic [EW-1:0]      wdata, rdata;
	logic [LW-1:0]      head_rdata, head, nxt, nsteps, head_wdata;
	logic [BW-1:0]      head_raddr;
	logic [31:0]        e_key, e_val;
	logic [LW-1:0]      e_link;

	assign {e_key, e_val, e_link} = rdata;
	assign head = hv_q[b_q] ? head_rdata : '0;
	assign head_raddr = bucket_of(req.key);
	assign head_wdata = used_q + LW'(1);
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = (state_q == ST_OUT);
	assign rsp.found = o_q.found;
	assign rsp.read_value = o_q.read_value;
	assign rsp.full_res = o_q.full_res;

	// walk: ST_HEAD starts at the head, each ST_CHECK compares one entry
	assign hit = (state_q == ST_CHECK) && (e_key == r_q.key);
	assign walking = (state_q == ST_HEAD) || (state_q == ST_CHECK && !hit);
	assign nxt = (state_q == ST_HEAD) ? head : e_link;
	assign nsteps = (state_q == ST_HEAD) ? '0 : steps_q + LW'(1);
	assign stop = nxt == '0 || nxt > LW'(POOL_ENTRIES) || nsteps >= LW'(POOL_ENTRIES);
	assign step = walking && !stop;
	assign miss = walking && stop;
	assign add = miss && r_q.req_type == REQ_STORE && used_q < LW'(POOL_ENTRIES);
	assign raddr = PW'(nxt - LW'(1));

	chm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head_ram (
		.clk, .we(hwe), .waddr(b_q), .wdata(head_wdata), .raddr(head_raddr),
		.rdata(head_rdata)
	);

	chm_ram #(.WIDTH(EW), .DEPTH(POOL_ENTRIES)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		hwe = 1'b0;
		waddr = PW'(used_q);
		wdata = {r_q.key, r_q.store_value, LW'(0)};
		case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_HEAD;
			end
			ST_HEAD, ST_CHECK: begin
				if (hit) begin
					state_d = ST_OUT;
					if (r_q.req_type == REQ_STORE) begin
						we = 1'b1;
						waddr = PW'(cur_q - LW'(1));
						wdata = {r_q.key, r_q.store_value, e_link};
					end
				end else if (!stop) begin
					state_d = ST_CHECK;
				end else begin
					state_d = ST_OUT;
					if (add) begin
						we = 1'b1;
						if (state_q == ST_HEAD) hwe = 1'b1;
						else state_d = ST_LINK;
					end
				end
			end
			ST_LINK: begin
				we = 1'b1;
				waddr = PW'(last_q - LW'(1));
				wdata = {lsave_q, used_q};
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (rsp.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			hv_q <= '0;
		end else begin
			if (add) used_q <= used_q + LW'(1);
			if (hwe) hv_q[b_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			r_q <= '{req.req_type, req.key, req.store_value};
			b_q <= bucket_of(req.key);
		end
		if (step) begin
			cur_q <= nxt;
			steps_q <= nsteps;
		end
		if (state_q == ST_CHECK && !hit) begin
			last_q <= cur_q;
			lsave_q <= rdata[EW-1:LW];
		end
		if (hit || miss) begin
			o_q.found <= hit;
			o_q.read_value <= (hit && r_q.req_type == REQ_LOOKUP) ? e_val : 32'd0;
			o_q.full_res <= miss && r_q.req_type == REQ_STORE &&
			                used_q >= LW'(POOL_ENTRIES);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(o_q));
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid));
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= LW'(POOL_ENTRIES));
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q != ST_IDLE && state_q != ST_OUT);
	a_head_write: assert property (@(posedge clk) disable iff (!arst_n)
		hwe |-> state_q == ST_HEAD);
endmodule
`default_nettype wire

[tb/chained_hash_map_test.sv]
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_map_test;
	import chm_pkg::*;

	localparam int TIMEOUT_CYCLES = 2000000;

	typedef struct {
		logic        found;
		logic [31:0] read_value;
		logic        full_res;
	} map_rsp_t;

	logic clk;
	logic arst_n;

	chm_req_if req ();
	chm_rsp_if rsp ();

	chained_hash_map u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// Shadow map state
	logic [8:0]  head_q [BUCKETS];
	logic [31:0] ent_key [POOL_ENTRIES];
	logic [31:0] ent_val [POOL_ENTRIES];
	logic [8:0]  ent_next [POOL_ENTRIES];
	int unsigned used_cnt = 0;

	req_t     pending_q [$];
	map_rsp_t expected_q [$];
	logic [31:0] key_pool [$];

	int errors = 0;
	int rsp_count = 0;
	int hit_count = 0;
	int full_count = 0;
	int cycle_cnt = 0;
	int total_reqs = 0;
	int burst_left;
	int gap_left;
	int hold_left;
	bit long_hold_done;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned map_bucket(logic [31:0] k);
		logic [31:0] mag;
		mag = k[31] ? (32'd0 - k) : k;
		return mag % BUCKETS;
	endfunction

	function automatic map_rsp_t map_apply(req_t r);
		map_rsp_t    res;
		int unsigned b;
		int unsigned cur;
		int unsigned last;
		int unsigned hit;
		int unsigned steps;
		res = '{1'b0, 32'd0, 1'b0};
		b = map_bucket(r.key);
		cur = head_q[b];
		last = 0;
		hit = 0;
		steps = 0;
		while (cur != 0 && cur <= POOL_ENTRIES && steps < POOL_ENTRIES) begin
			if (ent_key[cur-1] == r.key) begin
				hit = cur;
				break;
			end
			last = cur;
			cur = ent_next[cur-1];
			steps++;
		end
		if (r.req_type == REQ_LOOKUP) begin
			if (hit != 0) begin
				res.found = 1'b1;
				res.read_value = ent_val[hit-1];
			end
		end else if (hit != 0) begin
			ent_val[hit-1] = r.store_value;
			res.found = 1'b1;
		end else if (used_cnt >= POOL_ENTRIES) begin
			res.full_res = 1'b1;
		end else begin
			ent_key[used_cnt] = r.key;
			ent_val[used_cnt] = r.store_value;
			ent_next[used_cnt] = 9'd0;
			if (last == 0)
				head_q[b] = 9'(used_cnt + 1);
			else
				ent_next[last-1] = 9'(used_cnt + 1);
			used_cnt++;
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
		$display("mismatch on %s: got %h, expected %h (response %0d)", what, got, exp,
			rsp_count);
		errors++;
	endtask

	task automatic add_req(req_type_t t, logic [31:0] k, logic [31:0] v);
		req_t r;
		r.req_type = t;
		r.key = k;
		r.store_value = v;
		pending_q.push_back(r);
		total_reqs++;
		if (t == REQ_STORE)
			key_pool.push_back(k);
	endtask

	function automatic logic [31:0] pick_key();
		if (key_pool.size() > 0 && $urandom_range(0, 99) < 60)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($urandom_range(0, 511)) - 32'd256;
			2: return {$urandom_range(0, 3) == 0, 31'($urandom)};
			default: return 32'(($urandom_range(0, 7) * BUCKETS) + $urandom_range(0, 2));
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.req_type <= 1'b0;
			req.key <= '0;
			req.store_value <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (req.valid && req.ready)
				void'(pending_q.pop_front());
			if (req.valid && !req.ready) begin
				// hold the offered transaction
			end else if (gap_left > 0) begin
				req.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else begin
				if (pending_q.size() > 0) begin
					req_t nx;
					nx = pending_q[0];
					req.valid <= 1'b1;
					req.req_type <= nx.req_type;
					req.key <= nx.key;
					req.store_value <= nx.store_value;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 30);
						if (req.valid && req.ready && $urandom_range(0, 2) == 0) begin
							req.valid <= 1'b0;
							gap_left <= $urandom_range(0, 8);
						end
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// model update on accepted request
	always @(posedge clk) begin
		if (!arst_n) begin
			foreach (head_q[i])
				head_q[i] = 9'd0;
			used_cnt = 0;
		end else if (req.valid && req.ready) begin
			expected_q.push_back(map_apply('{req.req_type, req.key, req.store_value}));
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected transaction", 32'd1, 32'd0);
			end else begin
				map_rsp_t e;
				e = expected_q.pop_front();
				if (rsp.found !== e.found)
					report_mismatch("found", 32'(rsp.found), 32'(e.found));
				if (rsp.read_value !== e.read_value)
					report_mismatch("read_value", rsp.read_value, e.read_value);
				if (rsp.full_res !== e.full_res)
					report_mismatch("full_res", 32'(rsp.full_res), 32'(e.full_res));
				if (e.found)
					hit_count++;
				if (e.full_res)
					full_count++;
			end
			rsp_count++;
		end
	end

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold_left <= 0;
			long_hold_done <= 1'b0;
		end else begin
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!long_hold_done && rsp_count >= 400) begin
				rsp.ready <= 1'b0;
				hold_left <= 300;
				long_hold_done <= 1'b1;
			end else if ((cycle_cnt / 500) % 3 == 0) begin
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 60) == 0)
					hold_left <= $urandom_range(2, 20);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= TIMEOUT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		logic [31:0] k;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		add_req(REQ_LOOKUP, 32'd0, 32'hFFFF_FFFF);
		add_req(REQ_STORE, 32'd0, 32'hFFFF_FFFF);
		add_req(REQ_LOOKUP, 32'd0, 32'd0);
		add_req(REQ_STORE, 32'h8000_0000, 32'hA5A5_5A5A);
		add_req(REQ_STORE, 32'h7FFF_FFFF, 32'd0);
		add_req(REQ_STORE, 32'hFFFF_FFFF, 32'd1);
		add_req(REQ_STORE, 32'd1, 32'd2);
		add_req(REQ_STORE, 32'd64, 32'd3);
		add_req(REQ_STORE, 32'hFFFF_FFC0, 32'd4);
		add_req(REQ_LOOKUP, 32'h8000_0000, 32'd0);
		add_req(REQ_LOOKUP, 32'h7FFF_FFFF, 32'd0);
		add_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'd0);
		add_req(REQ_LOOKUP, 32'd1, 32'd0);
		add_req(REQ_LOOKUP, 32'd64, 32'd0);
		add_req(REQ_LOOKUP, 32'hFFFF_FFC0, 32'd0);
		add_req(REQ_LOOKUP, 32'd128, 32'd0);
		add_req(REQ_STORE, 32'd64, 32'h1234_5678);
		add_req(REQ_LOOKUP, 32'd64, 32'd0);

		// random: fill pool, then run against a full pool
		for (int i = 0; i < 1400; i++) begin
			if ($urandom_range(0, 99) < 55) begin
				k = pick_key();
				add_req(REQ_STORE, k, (i % 7 == 0) ? 32'd0 : 32'($urandom));
			end else begin
				k = pick_key();
				add_req(REQ_LOOKUP, k, 32'($urandom));
			end
		end

		while (rsp_count < total_reqs)
			@(negedge clk);
		repeat (50) @(posedge clk);
		$display("%0d responses checked, %0d hits, %0d stores dropped on a full pool",
			rsp_count, hit_count, full_count);
		$display("pool entries used: %0d of %0d; receiver long hold exercised: %0d",
			used_cnt, POOL_ENTRIES, long_hold_done);
		if (errors == 0 && expected_q.size() == 0 && rsp_count == total_reqs)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
`default_nettype wire
